>>> hw/rtl/ssmuc_pkg.sv
package ssmuc_pkg;

  localparam int unsigned MAX_CAPACITY_DEF = 1024;

  localparam int unsigned CAP_W = 11;
  localparam int unsigned WT_W  = 16;
  localparam int unsigned SUM_W = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_DRAIN,
    ST_RES_RD,
    ST_RES_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // take the input word
    logic rd_go;     // read row[w], row[w-wt], step w down
    logic rd_cap;    // read row[cap]
    logic out_load;  // move row[cap] into the output register
    logic clr_en;    // zero one row entry
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic upd_ok;     // incoming weight is nonzero and fits the capacity
    logic in_last;    // incoming word closes the set
    logic step_last;  // w has reached the weight
    logic item_last;  // held word closes the set
    logic out_free;   // output register can take a word this cycle
    logic clr_done;   // clear pointer is on the top entry
  } sts_t;

endpackage

>>> hw/rtl/ssmuc_ctrl.sv
module ssmuc_ctrl
  import ssmuc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  sts_t   sts,
  output logic   in_ready,
  output cmd_t   cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.upd_ok)       state_nxt = ST_UPD;
          else if (sts.in_last) state_nxt = ST_RES_RD;
        end
      end
      ST_UPD: begin
        if (sts.step_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = sts.item_last ? ST_RES_RD : ST_IDLE;
      end
      ST_RES_RD: begin
        state_nxt = ST_RES_WAIT;
      end
      ST_RES_WAIT: begin
        if (sts.out_free) state_nxt = ST_CLEAR;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_UPD: begin
        cmd.rd_go = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_RES_RD: begin
        cmd.rd_cap = 1'b1;
      end
      ST_RES_WAIT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/ssmuc_dp.sv
module ssmuc_dp
  import ssmuc_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [CAP_W-1:0] cfg_capacity,
  input  logic [WT_W-1:0]  in_item_weight,
  input  logic             in_last_item,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [SUM_W-1:0] out_best_sum,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int unsigned DEPTH = MAX_CAPACITY + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW    = ((AW > SUM_W) ? AW : SUM_W) + 1;

  logic [SUM_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0] cap_r;
  logic [AW-1:0]    eff_cap;

  logic [AW-1:0]    wt_r;
  logic             last_r;
  logic [AW-1:0]    w_r;
  logic [AW-1:0]    clr_addr_r;

  logic             wr_vld_r;
  logic [AW-1:0]    wr_addr_r;
  logic [SUM_W-1:0] rd_a_r;
  logic [SUM_W-1:0] rd_b_r;

  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;

  logic [AW-1:0]    rd_a_addr;
  logic [AW-1:0]    rd_b_addr;
  logic [TW-1:0]    take;
  logic [TW-1:0]    keep;
  logic [SUM_W-1:0] upd_val;

  // capacity register; eff_cap below saturates it to MAX_CAPACITY
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_capacity;
    end
  end

  always_comb begin
    if (32'(cap_r) > 32'(MAX_CAPACITY)) eff_cap = AW'(MAX_CAPACITY);
    else                                eff_cap = AW'(cap_r);
  end

  assign sts.upd_ok    = (in_item_weight != '0) &&
                         (32'(in_item_weight) <= 32'(eff_cap));
  assign sts.in_last   = in_last_item;
  assign sts.step_last = (w_r == wt_r);
  assign sts.item_last = last_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.clr_done  = (clr_addr_r == AW'(MAX_CAPACITY));

  // item and sweep pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wt_r   <= AW'(in_item_weight);
      last_r <= in_last_item;
      w_r    <= eff_cap;
    end else if (cmd.rd_go) begin
      w_r    <= w_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      wr_vld_r   <= 1'b0;
    end else begin
      wr_vld_r <= cmd.rd_go;
      if (cmd.clr_en) begin
        clr_addr_r <= sts.clr_done ? '0 : clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_go) wr_addr_r <= w_r;
  end

  // row memory: two registered reads, one write
  assign rd_a_addr = cmd.rd_cap ? eff_cap : w_r;
  assign rd_b_addr = w_r - wt_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_go || cmd.rd_cap) rd_a_r <= mem[rd_a_addr];
    if (cmd.rd_go)               rd_b_r <= mem[rd_b_addr];
  end

  // row[w] = max(row[w], wt + row[w - wt]); lower entries are still old
  assign take    = TW'(wt_r) + TW'(rd_b_r);
  assign keep    = TW'(rd_a_r);
  assign upd_val = (take > keep) ? SUM_W'(take) : rd_a_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_vld_r) begin
      mem[wr_addr_r] <= upd_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_sum_r <= rd_a_r;
  end

  assign out_valid    = out_valid_r;
  assign out_best_sum = out_sum_r;

endmodule

>>> hw/rtl/subset_sum_max_under_capacity_core.sv
// Channel | Ports                             | Word
// --------+-----------------------------------+-------------------------------
// cfg     | cfg_valid / cfg_ready             | cfg_capacity (11b)
// in      | in_valid / in_ready               | in_item_weight (16b), in_last_item
// out     | out_valid / out_ready             | out_best_sum (11b)
//
// An input word with 0 < W <= C (C is the capacity saturated to MAX_CAPACITY) is accepted, then
// the row sweep, one entry per cycle, walks w from C down to W and a drain state lets the last
// write land; any other word is only accepted. A word marked last adds the result read plus a
// clear sweep of MAX_CAPACITY + 1 entries; the same sweep runs after reset before in_ready rises.
// A result waiting in the output register does not stop new input words; only
// a second result stalls until the first is taken. cfg_ready is always high.
module subset_sum_max_under_capacity_core
  import ssmuc_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_capacity,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WT_W-1:0]  in_item_weight,
  input  logic             in_last_item,

  output logic             out_valid,
  input  logic             out_ready,
  output logic [SUM_W-1:0] out_best_sum
);

  cmd_t cmd;
  sts_t sts;

  // the user must change capacity only between sets, the block does not enforce it; writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: clear sweep, accept, row sweep, drain, result read, hand-off
  ssmuc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // row memory, update pipeline (read, max, write-back) and output register
  ssmuc_dp #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_capacity   (cfg_capacity),
    .in_item_weight (in_item_weight),
    .in_last_item   (in_last_item),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_best_sum   (out_best_sum),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssmuc_pkg::*;

  // Worst case per word: a full sweep of the row, then the
  // result read and the clear sweep on a closing word. Settle time covers both.
  localparam int SETTLE_CYCLES = 2 * (MAX_CAPACITY_DEF + 1) + 16;
  localparam int HOLD_CYCLES   = 3000;
  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int PHASE_ITEMS   = 180;

  // Directed plan: capacity writes and input words, one per row.
  typedef enum logic [0:0] {
    ROW_CAPACITY,
    ROW_WEIGHT
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [WT_W-1:0]   value;   // capacity in the low bits for ROW_CAPACITY
    logic              last;
    logic              typed;   // sum below is known by hand
    logic [SUM_W-1:0]  sum;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;

  plan_row_t plan [PLAN_ROWS] = '{
    // reset capacity 1024: empty weight, all-ones weight, exact fit, one over
    '{ROW_WEIGHT,   16'd0,     1'b1, 1'b1, 11'd0},
    '{ROW_WEIGHT,   16'hFFFF,  1'b1, 1'b1, 11'd0},
    '{ROW_WEIGHT,   16'd1024,  1'b1, 1'b1, 11'd1024},
    '{ROW_WEIGHT,   16'd1025,  1'b1, 1'b1, 11'd0},
    // capacity zero: nothing fits
    '{ROW_CAPACITY, 16'd0,     1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd1,     1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd0,     1'b1, 1'b1, 11'd0},
    // all-ones capacity saturates to the table size
    '{ROW_CAPACITY, 16'd2047,  1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd700,   1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd500,   1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd324,   1'b1, 1'b1, 11'd1024},
    // smallest nonzero capacity
    '{ROW_CAPACITY, 16'd1,     1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd1,     1'b1, 1'b1, 11'd1},
    '{ROW_CAPACITY, 16'd10,    1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd6,     1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd7,     1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd3,     1'b1, 1'b0, 11'd0},
    // capacity raised mid-set: upper entries never saw the first word
    '{ROW_CAPACITY, 16'd5,     1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd3,     1'b0, 1'b0, 11'd0},
    '{ROW_CAPACITY, 16'd20,    1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd4,     1'b1, 1'b0, 11'd0},
    // back to full size, overflow pair
    '{ROW_CAPACITY, 16'd1024,  1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd1023,  1'b0, 1'b0, 11'd0},
    '{ROW_WEIGHT,   16'd2,     1'b1, 1'b0, 11'd0}
  };

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             cfg_valid      = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_capacity   = '0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [WT_W-1:0]  in_item_weight = '0;
  logic             in_last_item   = 1'b0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [SUM_W-1:0] out_best_sum;

  // Shadow of the block: capacity register and the best-sum row.
  logic [CAP_W-1:0] cap_shadow;
  logic [SUM_W-1:0] reach_row [0:MAX_CAPACITY_DEF];
  logic [SUM_W-1:0] pending_sums [$];

  int mismatches    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_given    = 0;
  int hold_left     = 0;

  subset_sum_max_under_capacity_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item_weight (in_item_weight),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_sum   (out_best_sum)
  );

  always #5 clk = ~clk;

  // Fold one weight into the shadow row, top entry first so each weight is
  // used at most once. Returns 1 on a closing word, with the best sum.
  function automatic logic fold_weight(input logic [WT_W-1:0] wt, input logic last,
                                       output logic [SUM_W-1:0] sum);
    int lim;
    int w;
    int take;
    lim = (cap_shadow > MAX_CAPACITY_DEF) ? MAX_CAPACITY_DEF : int'(cap_shadow);
    if (wt != 0 && wt <= lim) begin
      for (w = lim; w >= wt; w--) begin
        take = wt + reach_row[w - wt];
        if (take > reach_row[w]) reach_row[w] = SUM_W'(take);
      end
    end
    sum = reach_row[lim];
    if (last) begin
      foreach (reach_row[i]) reach_row[i] = '0;
    end
    return last;
  endfunction

  // Offer one word, with a random gap first; the sum pushed is the typed one
  // where the plan gives it, the shadow's otherwise.
  task automatic send_item(input logic [WT_W-1:0] wt, input logic last,
                           input logic typed, input logic [SUM_W-1:0] typed_sum);
    logic [SUM_W-1:0] sum;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_item_weight <= wt;
    in_last_item   <= last;
    do @(posedge clk); while (!in_ready);
    if (fold_weight(wt, last, sum)) pending_sums.push_back(typed ? typed_sum : sum);
  endtask

  // Capacity only changes with the block idle: all sums out, sweeps finished.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cap_shadow = cap;
  endtask

  // Random segments: mostly small capacities with well-formed sets, a few
  // large or saturating ones, and some zero, oversize and full-width weights.
  task automatic random_phase(input int n_items);
    int sent;
    int seg_len;
    int lim;
    int pick;
    int k;
    logic [CAP_W-1:0] cap;
    logic [WT_W-1:0]  wt;
    logic             last;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0:       cap = '0;
        1:       cap = CAP_RESET;
        2:       cap = CAP_W'($urandom_range(1025, 2047));
        3:       cap = CAP_W'($urandom);
        default: cap = CAP_W'($urandom_range(1, 48));
      endcase
      write_capacity(cap);
      lim = (cap > MAX_CAPACITY_DEF) ? MAX_CAPACITY_DEF : int'(cap);
      // large rows sweep slowly, so keep those segments short
      seg_len = (lim > 64) ? $urandom_range(4, 10) : $urandom_range(16, 32);
      for (k = 0; k < seg_len; k++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)                wt = '0;
        else if (pick == 1)           wt = WT_W'($urandom);
        else if (pick == 2)           wt = WT_W'(lim + 1 + $urandom_range(0, 3));
        else if (pick == 3 || lim == 0) wt = WT_W'(lim);
        else                          wt = WT_W'($urandom_range(1, lim));
        last = (k == seg_len - 1) || ($urandom_range(0, 5) == 0);
        send_item(wt, last, 1'b0, '0);
      end
      sent += seg_len;
    end
  endtask

  // Receiver: random ready, or a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_given != hold_asked) begin
      out_ready  <= 1'b0;
      hold_given <= hold_asked;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: every accepted word against the oldest expected sum.
  always @(posedge clk) begin
    logic [SUM_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        $error("best_sum: no word expected, actual %0d", out_best_sum);
        mismatches++;
      end else begin
        want = pending_sums.pop_front();
        if (out_best_sum !== want) begin
          $error("best_sum: expected %0d, actual %0d", want, out_best_sum);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int k;
    cap_shadow = CAP_RESET;
    foreach (reach_row[i]) reach_row[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sender sparse gaps, receiver mostly stalled
    send_idle_pct = 20;
    recv_idle_pct = 71;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAPACITY) write_capacity(plan[i].value[CAP_W-1:0]);
      else send_item(plan[i].value, plan[i].last, plan[i].typed, plan[i].sum);
    end
    random_phase(PHASE_ITEMS);

    // roles swapped
    send_idle_pct = 71;
    recv_idle_pct = 20;
    random_phase(PHASE_ITEMS);

    // no idling; first a long receiver hold-off with short sets so a second
    // sum backs up behind the output register and in_ready drops
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(CAP_W'(8));
    hold_asked++;
    for (k = 0; k < 24; k++) send_item(WT_W'($urandom_range(1, 8)), (k % 3) == 2, 1'b0, '0);
    random_phase(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> subset_sum_max_under_capacity_core.f
hw/rtl/ssmuc_pkg.sv
hw/rtl/ssmuc_ctrl.sv
hw/rtl/ssmuc_dp.sv
hw/rtl/subset_sum_max_under_capacity_core.sv
bench/testbench.sv
